@@ hdl/cfpc_pkg.sv @@
// Package: shared types, constants and the CRC byte step for the framed packet checker.
`timescale 1ns / 1ps
`default_nettype none

package cfpc_pkg;

  // CRC16, reflected polynomial, all-ones preset
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Register reset values
  localparam logic [7:0] StartByteReset  = 8'd2;
  localparam logic [7:0] MaxPayloadReset = 8'd64;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_START_BYTE  = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_e;

  // Frame parser phase
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_KIND   = 3'd1,
    PH_LEN    = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_IDLE   = 3'd6
  } phase_e;

  // Frame verdict
  typedef enum logic [1:0] {
    VD_PENDING = 2'd0,
    VD_OK      = 2'd1,
    VD_BAD     = 2'd2
  } verdict_e;

  // Input request: one buffer byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // Result: verdict for one buffer
  typedef struct packed {
    logic       frame_ok;
    logic [7:0] payload_len;
    logic [7:0] frame_kind;
  } out_res_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crc_framed_packet_checker.sv @@
// Top level: streaming start/type/length frame checker with CRC16 verification.
// The result for a buffer is registered: it is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle unless stalled; the CRC byte step and parser update are combinational.
// Input stalls only while the result register holds a result that is itself stalled.
// Reset clears the parser state and the result register, and loads start byte 2 and
// maximum payload 64 into the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_packet_checker (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_idx_i,
  input  wire  [7:0]            cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire cfpc_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output cfpc_pkg::out_res_t    out_res_o
);

  // Configuration registers
  logic [7:0] start_byte_q;
  logic [7:0] max_payload_q;

  // Parser state
  cfpc_pkg::phase_e   phase_q, phase_d;
  cfpc_pkg::verdict_e verdict_q, verdict_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         declared_len_q, declared_len_d;
  logic [7:0]         payload_seen_q, payload_seen_d;
  logic [7:0]         kind_q, kind_d;
  logic [7:0]         crc_low_q, crc_low_d;

  // Result register
  logic               out_valid_q;
  cfpc_pkg::out_res_t out_res_q;
  cfpc_pkg::out_res_t res_d;

  logic        in_accept;
  logic [15:0] crc_next;
  logic [7:0]  seen_inc;

  // Hold input only while a finished result is blocked
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign crc_next = cfpc_pkg::crc16_step(crc_q, in_req_i.data_byte);
  assign seen_inc = 8'(payload_seen_q + 8'd1);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q  <= cfpc_pkg::StartByteReset;
      max_payload_q <= cfpc_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfpc_pkg::CFG_START_BYTE:  start_byte_q  <= cfg_data_i;
        cfpc_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the parser on the current byte; rearm after the last byte
  always_comb begin
    phase_d        = phase_q;
    verdict_d      = verdict_q;
    crc_d          = crc_q;
    declared_len_d = declared_len_q;
    payload_seen_d = payload_seen_q;
    kind_d         = kind_q;
    crc_low_d      = crc_low_q;

    case (phase_q)
      cfpc_pkg::PH_START: begin
        if (in_req_i.data_byte != start_byte_q) begin
          verdict_d = cfpc_pkg::VD_BAD;
          phase_d   = cfpc_pkg::PH_IDLE;
        end else begin
          crc_d   = crc_next;
          phase_d = cfpc_pkg::PH_KIND;
        end
      end
      cfpc_pkg::PH_KIND: begin
        kind_d  = in_req_i.data_byte;
        crc_d   = crc_next;
        phase_d = cfpc_pkg::PH_LEN;
      end
      cfpc_pkg::PH_LEN: begin
        if (in_req_i.data_byte > max_payload_q) begin
          verdict_d = cfpc_pkg::VD_BAD;
          phase_d   = cfpc_pkg::PH_IDLE;
        end else begin
          declared_len_d = in_req_i.data_byte;
          crc_d          = crc_next;
          phase_d        = (in_req_i.data_byte == 8'd0) ? cfpc_pkg::PH_CRC_LO
                                                        : cfpc_pkg::PH_BODY;
        end
      end
      cfpc_pkg::PH_BODY: begin
        crc_d          = crc_next;
        payload_seen_d = seen_inc;
        if (seen_inc >= declared_len_q) begin
          phase_d = cfpc_pkg::PH_CRC_LO;
        end
      end
      cfpc_pkg::PH_CRC_LO: begin
        crc_low_d = in_req_i.data_byte;
        phase_d   = cfpc_pkg::PH_CRC_HI;
      end
      cfpc_pkg::PH_CRC_HI: begin
        verdict_d = ({in_req_i.data_byte, crc_low_q} == crc_q) ? cfpc_pkg::VD_OK
                                                               : cfpc_pkg::VD_BAD;
        phase_d   = cfpc_pkg::PH_IDLE;
      end
      default: ;
    endcase

    // Report the verdict, zero the fields of a failed frame
    res_d.frame_ok    = (verdict_d == cfpc_pkg::VD_OK);
    res_d.payload_len = res_d.frame_ok ? declared_len_d : 8'd0;
    res_d.frame_kind  = res_d.frame_ok ? kind_d : 8'd0;

    if (in_req_i.last_byte) begin
      phase_d        = cfpc_pkg::PH_START;
      verdict_d      = cfpc_pkg::VD_PENDING;
      crc_d          = cfpc_pkg::CrcInit;
      declared_len_d = 8'd0;
      payload_seen_d = 8'd0;
      kind_d         = 8'd0;
      crc_low_d      = 8'd0;
    end
  end

  // Update parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= cfpc_pkg::PH_START;
      verdict_q      <= cfpc_pkg::VD_PENDING;
      crc_q          <= cfpc_pkg::CrcInit;
      declared_len_q <= 8'd0;
      payload_seen_q <= 8'd0;
      kind_q         <= 8'd0;
      crc_low_q      <= 8'd0;
    end else if (in_accept) begin
      phase_q        <= phase_d;
      verdict_q      <= verdict_d;
      crc_q          <= crc_d;
      declared_len_q <= declared_len_d;
      payload_seen_q <= payload_seen_d;
      kind_q         <= kind_d;
      crc_low_q      <= crc_low_d;
    end
  end

  // Load the result on the last byte, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && in_req_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_res_q <= '0;
    end else if (in_accept && in_req_i.last_byte) begin
      out_res_q <= res_d;
    end
  end

  // Checks
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_req_i.last_byte |=> out_valid_o)
    else $error("last byte accepted without a result");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_req_i.last_byte |=> phase_q == cfpc_pkg::PH_START &&
      verdict_q == cfpc_pkg::VD_PENDING && crc_q == cfpc_pkg::CrcInit)
    else $error("parser not rearmed after last byte");

  a_idle_has_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfpc_pkg::PH_IDLE |-> verdict_q != cfpc_pkg::VD_PENDING)
    else $error("idle phase without a verdict");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfpc_pkg::PH_BODY |-> payload_seen_q < declared_len_q)
    else $error("payload count overran declared length");

  a_bad_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.frame_ok |->
      out_res_o.payload_len == 8'd0 && out_res_o.frame_kind == 8'd0)
    else $error("failed frame reports nonzero fields");

endmodule

`default_nettype wire

@@ tb/crc_framed_packet_checker_tb.sv @@
// Testbench: random and directed buffers through the framed packet checker, verdicts scored.
`timescale 1ns / 1ps

localparam logic [15:0] CrcReflPoly   = 16'hA001;
localparam logic [15:0] CrcSeed       = 16'hFFFF;
localparam logic [7:0]  StartDefault  = 8'd2;
localparam logic [7:0]  MaxLenDefault = 8'd64;
localparam int          MaxPrinted    = 50;

// Fold one byte into a reflected CRC16, data LSB first
function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] d);
  logic [15:0] c;
  logic        fb;
  c = acc;
  for (int i = 0; i < 8; i++) begin
    fb = c[0] ^ d[i];
    c  = {1'b0, c[15:1]};
    if (fb) c = c ^ CrcReflPoly;
  end
  return c;
endfunction

// Frame parser mirror and store of predicted verdicts
class frame_scoreboard;
  logic [7:0]          start_cfg;
  logic [7:0]          max_cfg;
  cfpc_pkg::phase_e    ph;
  logic [15:0]         crc;
  logic [7:0]          len_decl;
  logic [7:0]          len_seen;
  logic [7:0]          kind_seen;
  logic [7:0]          crc_lo;
  cfpc_pkg::verdict_e  vd;
  cfpc_pkg::out_res_t  verdict_q[$];
  int                  errors;

  function new();
    start_cfg = StartDefault;
    max_cfg   = MaxLenDefault;
    errors    = 0;
    rearm();
  endfunction

  function void rearm();
    ph        = cfpc_pkg::PH_START;
    crc       = CrcSeed;
    len_decl  = '0;
    len_seen  = '0;
    kind_seen = '0;
    crc_lo    = '0;
    vd        = cfpc_pkg::VD_PENDING;
  endfunction

  function void set_config(cfpc_pkg::cfg_idx_e idx, logic [7:0] data);
    if (idx == cfpc_pkg::CFG_START_BYTE) start_cfg = data;
    else max_cfg = data;
  endfunction

  // Advance the parser by one accepted byte; return 1 unless the byte is ignored
  function bit absorb_byte(cfpc_pkg::in_req_t req);
    cfpc_pkg::out_res_t res;
    bit                 used;
    logic [7:0]         b;
    b    = req.data_byte;
    used = (ph != cfpc_pkg::PH_IDLE) || req.last_byte;
    case (ph)
      cfpc_pkg::PH_START: begin
        if (b != start_cfg) begin
          vd = cfpc_pkg::VD_BAD;
          ph = cfpc_pkg::PH_IDLE;
        end else begin
          crc = crc16_fold(crc, b);
          ph  = cfpc_pkg::PH_KIND;
        end
      end
      cfpc_pkg::PH_KIND: begin
        kind_seen = b;
        crc       = crc16_fold(crc, b);
        ph        = cfpc_pkg::PH_LEN;
      end
      cfpc_pkg::PH_LEN: begin
        if (b > max_cfg) begin
          vd = cfpc_pkg::VD_BAD;
          ph = cfpc_pkg::PH_IDLE;
        end else begin
          len_decl = b;
          crc      = crc16_fold(crc, b);
          ph       = (b == 8'd0) ? cfpc_pkg::PH_CRC_LO : cfpc_pkg::PH_BODY;
        end
      end
      cfpc_pkg::PH_BODY: begin
        crc      = crc16_fold(crc, b);
        len_seen = len_seen + 8'd1;
        if (len_seen >= len_decl) ph = cfpc_pkg::PH_CRC_LO;
      end
      cfpc_pkg::PH_CRC_LO: begin
        crc_lo = b;
        ph     = cfpc_pkg::PH_CRC_HI;
      end
      cfpc_pkg::PH_CRC_HI: begin
        vd = ({b, crc_lo} == crc) ? cfpc_pkg::VD_OK : cfpc_pkg::VD_BAD;
        ph = cfpc_pkg::PH_IDLE;
      end
      default: ;
    endcase
    // Emit a verdict on the final byte, then rearm
    if (req.last_byte) begin
      res = '0;
      if (vd == cfpc_pkg::VD_OK) begin
        res.frame_ok    = 1'b1;
        res.payload_len = len_decl;
        res.frame_kind  = kind_seen;
      end
      verdict_q.push_back(res);
      rearm();
    end
    return used;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("%0t ns: %s", $time, msg);
  endtask

  task check_verdict(cfpc_pkg::out_res_t got);
    cfpc_pkg::out_res_t want;
    if (verdict_q.size() == 0) begin
      report($sformatf("verdict with none pending: ok=%0b len=%0d kind=%0h",
                       got.frame_ok, got.payload_len, got.frame_kind));
      return;
    end
    want = verdict_q.pop_front();
    if (got.frame_ok !== want.frame_ok)
      report($sformatf("frame_ok %b, want %b", got.frame_ok, want.frame_ok));
    if (got.payload_len !== want.payload_len)
      report($sformatf("payload_len %0d, want %0d", got.payload_len, want.payload_len));
    if (got.frame_kind !== want.frame_kind)
      report($sformatf("frame_kind %h, want %h", got.frame_kind, want.frame_kind));
  endtask
endclass

module crc_framed_packet_checker_tb;

  localparam int NumPhases  = 6;
  localparam int PhaseItems = 321;
  localparam int CycleLimit = 300000;
  localparam int DrainWait  = 4;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  cfpc_pkg::cfg_idx_e cfg_idx_i   = cfpc_pkg::CFG_START_BYTE;
  logic [7:0]         cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  cfpc_pkg::in_req_t  in_req_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  cfpc_pkg::out_res_t out_res_o;

  frame_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_items   = 0;
  int cycles        = 0;

  crc_framed_packet_checker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i = rst_ni && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Score every accepted verdict
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(out_res_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one byte and hold it until accepted; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    in_req_i.data_byte = b;
    in_req_i.last_byte = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.absorb_byte(in_req_i)) phase_items++;
    @(negedge clk_i);
  endtask

  task automatic send_buffer(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Wait for every pending verdict, then let the block settle
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.verdict_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfpc_pkg::cfg_idx_e idx, input logic [7:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    sb.set_config(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Build a complete frame with random payload and a matching CRC
  function automatic void make_frame(ref logic [7:0] q[$], input logic [7:0] sop,
                                     input logic [7:0] kind, input logic [7:0] n);
    logic [15:0] c;
    q.delete();
    q.push_back(sop);
    q.push_back(kind);
    q.push_back(n);
    for (int i = 0; i < int'(n); i++) q.push_back(8'($urandom_range(0, 255)));
    c = CrcSeed;
    foreach (q[i]) c = crc16_fold(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  // Mostly short payloads, now and then up to the configured limit
  function automatic logic [7:0] pick_len(input logic [7:0] cap);
    int r;
    int top;
    r = $urandom_range(0, 99);
    if (r < 80) top = 12;
    else if (r < 95) top = 40;
    else top = 255;
    if (top > int'(cap)) top = int'(cap);
    return 8'($urandom_range(0, top));
  endfunction

  function automatic void cut_to(ref logic [7:0] q[$], input int keep);
    while (q.size() > keep) void'(q.pop_back());
  endfunction

  // One random buffer: mostly good frames, the rest damaged or noise
  task automatic random_buffer();
    logic [7:0] q[$];
    logic [7:0] flip;
    int         r;
    int         idx;
    r = $urandom_range(0, 99);
    make_frame(q, sb.start_cfg, 8'($urandom_range(0, 255)), pick_len(sb.max_cfg));
    if (r < 68) begin
      // good frame, sometimes with trailing bytes
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 78) begin
      // flip one bit in payload or CRC
      idx    = $urandom_range(3, q.size() - 1);
      q[idx] = q[idx] ^ (8'h01 << $urandom_range(0, 7));
    end else if (r < 86) begin
      // end the buffer early
      cut_to(q, $urandom_range(1, q.size() - 1));
    end else if (r < 91) begin
      // wrong start byte
      flip = 8'($urandom_range(1, 255));
      q[0] = sb.start_cfg ^ flip;
      cut_to(q, $urandom_range(1, 4));
    end else if (r < 96 && sb.max_cfg != 8'hFF) begin
      // length above the limit
      q[2] = 8'($urandom_range(int'(sb.max_cfg) + 1, 255));
      cut_to(q, $urandom_range(3, 6));
    end else begin
      // noise
      q.delete();
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
    end
    send_buffer(q);
  endtask

  // Short directed set under the reset register values
  task automatic directed_buffers();
    logic [7:0] q[$];
    // good empty frame, all-ones type
    make_frame(q, StartDefault, 8'hFF, 8'd0);
    send_buffer(q);
    // wrong start byte
    q = {8'hFF, 8'h00};
    send_buffer(q);
    // length one above the limit
    q = {StartDefault, 8'h00, MaxLenDefault + 8'd1};
    send_buffer(q);
    // buffer of the start byte alone
    q = {StartDefault};
    send_buffer(q);
    // CRC mismatch in the high byte
    make_frame(q, StartDefault, 8'h5A, 8'd0);
    q[4] = q[4] ^ 8'h80;
    send_buffer(q);
    // good frame followed by a trailing byte
    make_frame(q, StartDefault, 8'h01, 8'd1);
    q.push_back(8'h00);
    send_buffer(q);
  endtask

  initial begin
    logic [7:0] frame_start;
    logic [7:0] len_limit;
    logic [7:0] q[$];
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      // Reprogram only once the block is idle
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            frame_start = 8'h00;
            len_limit   = 8'd250;
          end
          2: begin
            frame_start = 8'hFF;
            len_limit   = 8'd0;
          end
          3: begin
            frame_start = 8'($urandom_range(0, 255));
            len_limit   = 8'hFF;
          end
          4: begin
            frame_start = 8'($urandom_range(0, 255));
            len_limit   = 8'($urandom_range(1, 250));
          end
          default: begin
            frame_start = 8'hA5;
            len_limit   = 8'd5;
          end
        endcase
        cfg_write(cfpc_pkg::CFG_START_BYTE, frame_start);
        cfg_write(cfpc_pkg::CFG_MAX_PAYLOAD, len_limit);
      end

      if (p < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 60;
      end else if (p < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      phase_items = 0;
      if (p == 0) directed_buffers();
      // Longest frame once the limit allows it
      if (sb.max_cfg > 8'd250) begin
        make_frame(q, sb.start_cfg, 8'($urandom_range(0, 255)), sb.max_cfg);
        send_buffer(q);
      end

      while (phase_items < PhaseItems) random_buffer();
    end

    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/cfpc_pkg.sv
hdl/crc_framed_packet_checker.sv
tb/crc_framed_packet_checker_tb.sv
